// ----- design/srg_pkg.sv -----
package srg_pkg;

    localparam int SPEED_W     = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int TABLE_LEN   = 5;
    localparam int ACCEL_STEPS = 5;   // entries searched, 1..8, capped at TABLE_LEN
    localparam int PCT_W       = 7;
    localparam int STEP_W      = 8;
    // 100*speed and 100*middle + (target-middle)*pct fit in 27 signed bits
    localparam int CMP_W       = 28;

    localparam logic [SPEED_W-1:0] SPEED_MAX    = SPEED_W'(200000);
    localparam logic [SPEED_W-1:0] MIDDLE_RESET = SPEED_W'(150000);
    localparam logic [STEP_W-1:0]  SLOW_STEP    = STEP_W'(2);
    localparam logic [STEP_W-1:0]  FALL_STEP    = STEP_W'(50);
    localparam logic [STEP_W-1:0]  DEAD_BAND    = STEP_W'(100);
    localparam logic [PCT_W-1:0]   PCT_SCALE    = PCT_W'(100);

    typedef logic [PCT_W-1:0]  t_pct_tab  [TABLE_LEN];
    typedef logic [STEP_W-1:0] t_step_tab [TABLE_LEN];

    // fraction of the way from middle to target, and the step used below it
    localparam t_pct_tab  BOOST_PCT  = '{7'd15, 7'd30, 7'd50, 7'd75, 7'd100};
    localparam t_step_tab BOOST_STEP = '{8'd200, 8'd100, 8'd50, 8'd25, 8'd20};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_ENABLE  = 2'd0,
        CFG_BOOST_MODE   = 2'd1,
        CFG_MIDDLE_SPEED = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               ramp_enable;
        logic               boost_mode;
        logic [SPEED_W-1:0] middle_speed;
    } t_cfg;

endpackage

// ----- design/srg_step.sv -----
module srg_step #(
    parameter int ACCEL_STEPS = srg_pkg::ACCEL_STEPS
) (
    input  srg_pkg::t_cfg                 i_cfg,
    input  logic [srg_pkg::SPEED_W-1:0]   i_speed,
    input  logic [srg_pkg::SPEED_W-1:0]   i_target,
    output logic [srg_pkg::SPEED_W-1:0]   o_speed
);

    localparam int W  = srg_pkg::SPEED_W;
    localparam int CW = srg_pkg::CMP_W;
    localparam int NSTEPS = (ACCEL_STEPS < srg_pkg::TABLE_LEN) ?
                            ACCEL_STEPS : srg_pkg::TABLE_LEN;

    logic signed [CW-1:0]          s_spd100;
    logic signed [CW-1:0]          s_mid;
    logic signed [CW-1:0]          s_diff;
    logic signed [CW-1:0]          s_rhs [srg_pkg::TABLE_LEN];
    logic [srg_pkg::STEP_W-1:0]    boost_step;
    logic [W:0]                    spd_ext;
    logic [W:0]                    tgt_ext;
    logic [W:0]                    rise_sum;
    logic [W:0]                    slow_sum;
    logic                          below_band;
    logic                          above_band;

    assign spd_ext  = {1'b0, i_speed};
    assign tgt_ext  = {1'b0, i_target};
    assign s_spd100 = CW'(i_speed) * CW'(srg_pkg::PCT_SCALE);
    assign s_mid    = CW'(i_cfg.middle_speed);
    assign s_diff   = CW'(i_target) - s_mid;

    // first entry whose threshold lies above the speed wins; none gives 0
    always_comb begin
        boost_step = '0;
        for (int i = srg_pkg::TABLE_LEN - 1; i >= 0; i--) begin
            s_rhs[i] = s_mid * CW'(srg_pkg::PCT_SCALE)
                     + s_diff * CW'(srg_pkg::BOOST_PCT[i]);
            if (i < NSTEPS && s_spd100 < s_rhs[i]) begin
                boost_step = srg_pkg::BOOST_STEP[i];
            end
        end
    end

    assign below_band = (spd_ext + (W+1)'(srg_pkg::DEAD_BAND)) < tgt_ext;
    assign above_band = spd_ext > (tgt_ext + (W+1)'(srg_pkg::DEAD_BAND));
    assign rise_sum   = spd_ext + (W+1)'(boost_step);
    assign slow_sum   = spd_ext + (W+1)'(srg_pkg::SLOW_STEP);

    always_comb begin
        o_speed = i_speed;
        if (!i_cfg.ramp_enable) begin
            o_speed = i_target;
        end else if (i_cfg.boost_mode) begin
            if (below_band) begin
                o_speed = (rise_sum > (W+1)'(srg_pkg::SPEED_MAX)) ?
                          srg_pkg::SPEED_MAX : rise_sum[W-1:0];
            end else if (above_band) begin
                o_speed = (i_speed < W'(srg_pkg::FALL_STEP)) ? '0 :
                          i_speed - W'(srg_pkg::FALL_STEP);
            end
        end else begin
            if (i_speed < i_target) begin
                o_speed = (slow_sum > (W+1)'(srg_pkg::SPEED_MAX)) ?
                          srg_pkg::SPEED_MAX : slow_sum[W-1:0];
            end else if (i_speed > i_target) begin
                o_speed = i_target;
            end
        end
    end

endmodule

// ----- design/speed_ramp_generator.sv -----
// Speed ramp generator: slew-limited speed tracking of a target, one result per tick.
// The result passes through the input register, one pass of logic and the result register.
// Throughput: one tick per cycle while the output is not stalled; a stalled result holds
// the input register.
// Reset (i_rst_n low, synchronous): speed 0, ramp enabled, boost off, middle 150000,
// both pipeline stages empty.
module speed_ramp_generator #(
    parameter int ACCEL_STEPS = srg_pkg::ACCEL_STEPS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // tick input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [srg_pkg::SPEED_W-1:0]           i_target_speed,
    // speed output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [srg_pkg::SPEED_W-1:0]           o_current_speed_out,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [srg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [srg_pkg::SPEED_W-1:0]           i_cfg_data
);

    localparam int W = srg_pkg::SPEED_W;

    srg_pkg::t_cfg   r_cfg;
    logic            r_in_valid;
    logic [W-1:0]    r_target;      // already saturated to the speed range
    logic            r_out_valid;
    logic [W-1:0]    r_speed;       // present speed, also the output payload
    logic [W-1:0]    n_speed;
    logic            out_free;
    logic            advance;
    logic            in_xfer;

    // Result register frees when empty or when its transfer happens this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && out_free;
    // Input register takes a new tick when empty or when it advances.
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign o_out_valid         = r_out_valid;
    assign o_current_speed_out = r_speed;
    assign o_cfg_ready         = 1'b1;

    // Config must be written only while idle, so no hazard with ticks in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_enable  <= 1'b1;
            r_cfg.boost_mode   <= 1'b0;
            r_cfg.middle_speed <= srg_pkg::MIDDLE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (srg_pkg::t_cfg_idx'(i_cfg_index))
                srg_pkg::CFG_RAMP_ENABLE:  r_cfg.ramp_enable  <= i_cfg_data[0];
                srg_pkg::CFG_BOOST_MODE:   r_cfg.boost_mode   <= i_cfg_data[0];
                srg_pkg::CFG_MIDDLE_SPEED: r_cfg.middle_speed <= i_cfg_data;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // Input stage: capture target, clamped to the top of the speed range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_target <= (i_target_speed > srg_pkg::SPEED_MAX) ?
                        srg_pkg::SPEED_MAX : i_target_speed;
        end
    end

    // Next speed from the present speed and the registered target.
    srg_step #(
        .ACCEL_STEPS (ACCEL_STEPS)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_speed  (r_speed),
        .i_target (r_target),
        .o_speed  (n_speed)
    );

    // Result stage: the speed register doubles as the output register,
    // so it only moves when the previous result has been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_speed     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_speed     <= n_speed;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
